[rtl/ddm_pkg.sv]
// Shared types, codes and constants of the differential-drive motor mixer.
package ddm_pkg;

	// Fixed-point scales.
	localparam int ONE_Q15       = 32768;
	localparam int Q15_BITS      = 15;
	localparam int GAIN_FRAC     = 14;
	localparam int SPEED_SCALE   = 2000;
	localparam int DUTY_FULL     = 100;
	localparam int DUTY_ON_SCALE = 1000;

	// Datapath widths.
	localparam int VEL_W  = 16;              // body speeds
	localparam int MAG_W  = 28;              // wheel speed magnitude, divisor
	localparam int WHL_W  = MAG_W + 1;       // signed wheel speed
	localparam int M_W    = 26;              // linear limit * SPEED_SCALE
	localparam int PROD_W = VEL_W + M_W;     // shared multiplier product
	localparam int DIVN_W = MAG_W + Q15_BITS; // divider dividend

	// Four-lane divider: both wheels and both body speeds share one divisor.
	localparam int DIV_LANES = 4;
	localparam int DIV_QBITS = 16;
	localparam int LANE_VL   = 0;
	localparam int LANE_VR   = 1;
	localparam int LANE_LIN  = 2;
	localparam int LANE_ANG  = 3;

	typedef enum logic {
		ACT_CMD  = 1'b0,
		ACT_TICK = 1'b1
	} action_t;

	typedef enum logic {
		KIND_TICK = 1'b0,
		KIND_STOP = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		DIR_OFF = 2'd0,
		DIR_FWD = 2'd1,
		DIR_REV = 2'd2
	} dir_t;

	typedef enum logic [2:0] {
		REG_LIN_LIMIT  = 3'd0,
		REG_ANG_LIMIT  = 3'd1,
		REG_TRACK      = 3'd2,
		REG_TIMEOUT    = 3'd3,
		REG_LEFT_MIN   = 3'd4,
		REG_RIGHT_MIN  = 3'd5,
		REG_LEFT_COMP  = 3'd6,
		REG_RIGHT_COMP = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic        invert;
		logic [15:0] back;
		logic [15:0] fwd;
	} comp_t;

	typedef struct packed {
		logic [14:0] lin_limit;
		logic [14:0] ang_limit;
		logic [11:0] track_mm;
		logic [15:0] timeout_ticks;
		logic [6:0]  left_min_duty;
		logic [6:0]  right_min_duty;
		comp_t       left_comp;
		comp_t       right_comp;
	} cfg_t;

	localparam comp_t COMP_RESET = '{invert: 1'b0, back: 16'h4000, fwd: 16'h4000};

	localparam cfg_t CFG_RESET = '{
		lin_limit:      15'd200,
		ang_limit:      15'd2000,
		track_mm:       12'd160,
		timeout_ticks:  16'd50,
		left_min_duty:  7'd90,
		right_min_duty: 7'd90,
		left_comp:      COMP_RESET,
		right_comp:     COMP_RESET
	};

	typedef struct packed {
		kind_t              kind;
		logic [6:0]         left_duty;
		dir_t               left_dir;
		logic [6:0]         right_duty;
		dir_t               right_dir;
		logic signed [15:0] body_linear;
		logic signed [15:0] body_angular;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CMD,
		ST_TICK,
		ST_MUL_WB,
		ST_MIX,
		ST_MAXD,
		ST_MULW,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_SIGN,
		ST_COMPL,
		ST_COMPR,
		ST_DUTY,
		ST_EMIT
	} state_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_CAPTURE,
		OP_CMD,
		OP_TICK,
		OP_MUL_WB,
		OP_MIX,
		OP_MAXD,
		OP_MULW,
		OP_DIV_GO,
		OP_SIGN,
		OP_COMPL,
		OP_COMPR,
		OP_DUTY
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   in_ready;
		logic   push;
	} ctl_cmd_t;

	typedef struct packed {
		logic zero_cmd;
		logic div_done;
	} dp_status_t;

endpackage

[rtl/ddm_if.sv]
// Handshake channels of the motor mixer: commands and ticks, results, configuration.
interface ddm_cmd_if;
	logic               valid;
	logic               ready;
	logic               action;
	logic signed [15:0] linear_cmd;
	logic signed [15:0] angular_cmd;

	modport source(output valid, action, linear_cmd, angular_cmd, input ready);
	modport sink(input valid, action, linear_cmd, angular_cmd, output ready);
endinterface

interface ddm_res_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [6:0]         left_duty;
	logic [1:0]         left_dir;
	logic [6:0]         right_duty;
	logic [1:0]         right_dir;
	logic signed [15:0] body_linear;
	logic signed [15:0] body_angular;

	modport source(output valid, kind, left_duty, left_dir, right_duty, right_dir,
		body_linear, body_angular, input ready);
	modport sink(input valid, kind, left_duty, left_dir, right_duty, right_dir,
		body_linear, body_angular, output ready);
endinterface

interface ddm_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [32:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[rtl/ddm_div.sv]
// Four-lane restoring divider sharing one divisor, one quotient bit per lane per cycle.
module ddm_div
	import ddm_pkg::*;
(
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [MAG_W-1:0]                     divisor,
	input  logic [DIV_LANES-1:0][DIVN_W-1:0]     dividend,
	output logic [DIV_LANES-1:0][DIV_QBITS-1:0]  quotient,
	output logic                                 busy
);

	localparam int CNT_W = $clog2(DIV_QBITS + 1);

	logic [DIV_LANES-1:0][MAG_W-1:0]     rem_q;
	logic [DIV_LANES-1:0][DIV_QBITS-1:0] quo_q;
	logic [DIV_LANES-1:0][MAG_W-1:0]     rem_n;
	logic [DIV_LANES-1:0]                ge;
	logic [CNT_W-1:0]                    cnt_q;
	logic                                busy_q;

	// The upper part of each dividend is below the divisor, so the quotient
	// fits in DIV_QBITS and the remainder never outgrows the divisor width.
	always_comb begin
		logic [MAG_W:0] trial;
		for (int i = 0; i < DIV_LANES; i++) begin
			trial    = {rem_q[i], quo_q[i][DIV_QBITS-1]};
			ge[i]    = trial >= {1'b0, divisor};
			rem_n[i] = ge[i] ? MAG_W'(trial - {1'b0, divisor}) : trial[MAG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIV_QBITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < DIV_LANES; i++) begin
				rem_q[i] <= MAG_W'(dividend[i][DIVN_W-1:DIV_QBITS]);
				quo_q[i] <= dividend[i][DIV_QBITS-1:0];
			end
		end else if (busy_q) begin
			for (int i = 0; i < DIV_LANES; i++) begin
				rem_q[i] <= rem_n[i];
				quo_q[i] <= {quo_q[i][DIV_QBITS-2:0], ge[i]};
			end
		end
	end

	assign quotient = quo_q;
	assign busy     = busy_q;

endmodule

[rtl/ddm_ctl.sv]
// Sequencing state machine of the motor mixer.
module ddm_ctl
	import ddm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_action,
	input  logic       out_free,
	input  dp_status_t status,
	output ctl_cmd_t   cmd
);

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n      = state_q;
		cmd.op       = OP_NOP;
		cmd.in_ready = 1'b0;
		cmd.push     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_CAPTURE;
					state_n = (action_t'(in_action) == ACT_TICK) ? ST_TICK : ST_CMD;
				end
			end
			ST_CMD: begin
				cmd.op  = OP_CMD;
				state_n = status.zero_cmd ? ST_EMIT : ST_IDLE;
			end
			ST_TICK: begin
				cmd.op  = OP_TICK;
				state_n = ST_MUL_WB;
			end
			ST_MUL_WB: begin
				cmd.op  = OP_MUL_WB;
				state_n = ST_MIX;
			end
			ST_MIX: begin
				cmd.op  = OP_MIX;
				state_n = ST_MAXD;
			end
			ST_MAXD: begin
				cmd.op  = OP_MAXD;
				state_n = ST_MULW;
			end
			ST_MULW: begin
				cmd.op  = OP_MULW;
				state_n = ST_DIV_GO;
			end
			ST_DIV_GO: begin
				cmd.op  = OP_DIV_GO;
				state_n = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (status.div_done) begin
					state_n = ST_SIGN;
				end
			end
			ST_SIGN: begin
				cmd.op  = OP_SIGN;
				state_n = ST_COMPL;
			end
			ST_COMPL: begin
				cmd.op  = OP_COMPL;
				state_n = ST_COMPR;
			end
			ST_COMPR: begin
				cmd.op  = OP_COMPR;
				state_n = ST_DUTY;
			end
			ST_DUTY: begin
				cmd.op  = OP_DUTY;
				state_n = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.push = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/ddm_dp.sv]
// Datapath of the motor mixer: stored command, mixing, scaling, compensation and duty.
module ddm_dp
	import ddm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  dp_op_t                  op,
	input  logic signed [VEL_W-1:0] linear_cmd,
	input  logic signed [VEL_W-1:0] angular_cmd,
	output dp_status_t              status,
	output res_t                    res
);

	localparam res_t STOP_RES = '{
		kind: KIND_STOP, left_duty: '0, left_dir: DIR_OFF,
		right_duty: '0, right_dir: DIR_OFF, body_linear: '0, body_angular: '0
	};

	function automatic logic [VEL_W-1:0] mag16(input logic signed [VEL_W-1:0] x);
		return x[VEL_W-1] ? VEL_W'(-x) : x;
	endfunction

	function automatic logic signed [VEL_W-1:0] clamp_lim(
		input logic signed [VEL_W-1:0] x,
		input logic [VEL_W-2:0]        lim
	);
		logic signed [VEL_W:0] xs, hi, lo;
		xs = {x[VEL_W-1], x};
		hi = {2'b00, lim};
		lo = -hi;
		if (xs > hi) begin
			return hi[VEL_W-1:0];
		end else if (xs < lo) begin
			return lo[VEL_W-1:0];
		end
		return x;
	endfunction

	function automatic logic [WHL_W-1:0] mag29(input logic signed [WHL_W-1:0] x);
		return x[WHL_W-1] ? WHL_W'(-x) : x;
	endfunction

	// Gain product back to Q1.15, saturated at full scale.
	function automatic logic [VEL_W-1:0] sat_gain(input logic [PROD_W-1:0] p);
		logic [PROD_W-GAIN_FRAC-1:0] q;
		q = p[PROD_W-1:GAIN_FRAC];
		return (q > (PROD_W-GAIN_FRAC)'(ONE_Q15)) ? VEL_W'(ONE_Q15) : q[VEL_W-1:0];
	endfunction

	function automatic logic [6:0] duty_of(input logic [VEL_W-1:0] a, input logic [6:0] m);
		logic [25:0] a_scaled;
		logic [6:0]  span;
		logic [22:0] p;
		logic [7:0]  sum;
		a_scaled = 26'(a) * 26'(DUTY_ON_SCALE);
		if (a_scaled < 26'(ONE_Q15)) begin
			return '0;
		end
		if (m >= 7'(DUTY_FULL)) begin
			return 7'(DUTY_FULL);
		end
		span = 7'(DUTY_FULL) - m;
		p    = 23'(a) * 23'(span);
		sum  = {1'b0, m} + p[22:Q15_BITS];
		return (sum > 8'(DUTY_FULL)) ? 7'(DUTY_FULL) : sum[6:0];
	endfunction

	function automatic dir_t dir_of(input logic [VEL_W-1:0] a, input logic neg);
		if (a == '0) begin
			return DIR_OFF;
		end
		return neg ? DIR_REV : DIR_FWD;
	endfunction

	// Stored command and its age.
	logic signed [VEL_W-1:0] stored_lin_q, stored_ang_q;
	logic [15:0]             age_q;

	// Working registers of one item.
	logic signed [VEL_W-1:0] lin_q, ang_q;
	logic [PROD_W-1:0]       prod_q, pv_q;
	logic signed [WHL_W-1:0] vl_q, vr_q;
	logic [MAG_W-1:0]        d_q;
	logic [VEL_W-1:0]        magl_q, magr_q, cl_q;
	logic                    negl_q, negr_q;
	res_t                    res_q;

	logic signed [VEL_W-1:0] clamp_v, clamp_w;
	logic [VEL_W-1:0]        absv, absw;
	logic [M_W-1:0]          m_full;
	logic                    m_zero;
	logic [15:0]             age_n;
	logic                    timed_out;
	logic [VEL_W-1:0]        mul_a;
	logic [M_W-1:0]          mul_b;
	logic [PROD_W-1:0]       mul_p;
	logic signed [WHL_W-1:0] vx, v2000, wmag, wterm, vl_n, vr_n;
	logic [MAG_W-1:0]        absl, absr, d_n;
	logic [DIV_LANES-1:0][DIVN_W-1:0]    dvd;
	logic [DIV_LANES-1:0][DIV_QBITS-1:0] quo;
	logic                    div_busy;
	logic [VEL_W-1:0]        ql, qr, qlin, qang, cr;

	assign clamp_v   = clamp_lim(lin_q, cfg.lin_limit);
	assign clamp_w   = clamp_lim(ang_q, cfg.ang_limit);
	assign absv      = mag16(stored_lin_q);
	assign absw      = mag16(stored_ang_q);
	assign m_full    = M_W'(cfg.lin_limit) * M_W'(SPEED_SCALE);
	assign m_zero    = cfg.lin_limit == '0;
	assign age_n     = (age_q == '1) ? age_q : age_q + 1'b1;
	assign timed_out = age_n > cfg.timeout_ticks;

	// One multiplier serves the track-width product, both body-speed products
	// and both gain products, one per cycle.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op)
			OP_MUL_WB: begin
				mul_a = absw;
				mul_b = M_W'(cfg.track_mm);
			end
			OP_MAXD: begin
				mul_a = absv;
				mul_b = m_full;
			end
			OP_MULW: begin
				mul_a = absw;
				mul_b = m_full;
			end
			OP_COMPL: begin
				mul_a = magl_q;
				mul_b = M_W'(negl_q ? cfg.left_comp.back : cfg.left_comp.fwd);
			end
			OP_COMPR: begin
				mul_a = magr_q;
				mul_b = M_W'(negr_q ? cfg.right_comp.back : cfg.right_comp.fwd);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Wheel speeds in units of 1/2000 mm/s.
	assign vx    = {{(WHL_W-VEL_W){stored_lin_q[VEL_W-1]}}, stored_lin_q};
	assign v2000 = vx * $signed(WHL_W'(SPEED_SCALE));
	assign wmag  = {1'b0, prod_q[MAG_W-1:0]};
	assign wterm = stored_ang_q[VEL_W-1] ? -wmag : wmag;
	assign vl_n  = v2000 - wterm;
	assign vr_n  = v2000 + wterm;

	assign absl = MAG_W'(mag29(vl_q));
	assign absr = MAG_W'(mag29(vr_q));

	always_comb begin
		d_n = MAG_W'(m_full);
		if (absl > d_n) begin
			d_n = absl;
		end
		if (absr > d_n) begin
			d_n = absr;
		end
	end

	assign dvd[LANE_VL]  = {absl, {Q15_BITS{1'b0}}};
	assign dvd[LANE_VR]  = {absr, {Q15_BITS{1'b0}}};
	assign dvd[LANE_LIN] = DIVN_W'(pv_q);
	assign dvd[LANE_ANG] = DIVN_W'(prod_q);

	ddm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (op == OP_DIV_GO),
		.divisor  (d_q),
		.dividend (dvd),
		.quotient (quo),
		.busy     (div_busy)
	);

	// A zero linear limit forces every scaled value to zero.
	assign ql   = m_zero ? '0 : quo[LANE_VL];
	assign qr   = m_zero ? '0 : quo[LANE_VR];
	assign qlin = m_zero ? '0 : quo[LANE_LIN];
	assign qang = m_zero ? '0 : quo[LANE_ANG];
	assign cr   = sat_gain(prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_lin_q <= '0;
			stored_ang_q <= '0;
			age_q        <= '0;
		end else if (op == OP_CMD) begin
			stored_lin_q <= clamp_v;
			stored_ang_q <= clamp_w;
			age_q        <= '0;
		end else if (op == OP_TICK) begin
			age_q <= age_n;
			if (timed_out) begin
				stored_lin_q <= '0;
				stored_ang_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_CAPTURE: begin
				lin_q <= linear_cmd;
				ang_q <= angular_cmd;
			end
			OP_CMD: begin
				res_q <= STOP_RES;
			end
			OP_MUL_WB: begin
				prod_q <= mul_p;
			end
			OP_MIX: begin
				vl_q <= vl_n;
				vr_q <= vr_n;
			end
			OP_MAXD: begin
				d_q    <= d_n;
				prod_q <= mul_p;
			end
			OP_MULW: begin
				pv_q   <= prod_q;
				prod_q <= mul_p;
			end
			OP_SIGN: begin
				magl_q <= ql;
				magr_q <= qr;
				negl_q <= vl_q[WHL_W-1] ^ cfg.left_comp.invert;
				negr_q <= vr_q[WHL_W-1] ^ cfg.right_comp.invert;
				res_q.body_linear  <= stored_lin_q[VEL_W-1] ? -$signed(qlin) : $signed(qlin);
				res_q.body_angular <= stored_ang_q[VEL_W-1] ? -$signed(qang) : $signed(qang);
			end
			OP_COMPL: begin
				prod_q <= mul_p;
			end
			OP_COMPR: begin
				cl_q   <= sat_gain(prod_q);
				prod_q <= mul_p;
			end
			OP_DUTY: begin
				res_q.kind       <= KIND_TICK;
				res_q.left_duty  <= duty_of(cl_q, cfg.left_min_duty);
				res_q.left_dir   <= dir_of(cl_q, negl_q);
				res_q.right_duty <= duty_of(cr, cfg.right_min_duty);
				res_q.right_dir  <= dir_of(cr, negr_q);
			end
			default: begin
			end
		endcase
	end

	assign status.zero_cmd = (clamp_v == '0) && (clamp_w == '0);
	assign status.div_done = !div_busy;
	assign res             = res_q;

	a_age_moves: assert property (@(posedge clk) disable iff (!arst_n)
		op == OP_TICK |=> age_q != '0)
		else $error("command age is zero after a tick");

	a_cmd_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		op == OP_CMD |=>
			stored_lin_q <= $signed({1'b0, $past(cfg.lin_limit)}) &&
			stored_lin_q >= -$signed({1'b0, $past(cfg.lin_limit)}))
		else $error("stored linear speed outside its limit");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		op == OP_SIGN |=> magl_q <= VEL_W'(ONE_Q15) && magr_q <= VEL_W'(ONE_Q15))
		else $error("normalised wheel value beyond full scale");

endmodule

[rtl/diff_drive_motor_mixer_top.sv]
// Top level of the differential-drive motor mixer: register file, control, datapath, output.
// A tick item steps through the tick update, the shared multiplier, mixing, the four-lane
// divider, sign, compensation and duty; the next item is taken once the result sits in
// the output register. A command item needs the command state, and the emit state as well
// to place the stop result when it is zero. The controller holds one item at a time.
// Asynchronous active-low reset clears the stored command, its age and the controller, and
// loads the register defaults; nothing is swept after reset.
module diff_drive_motor_mixer_top
	import ddm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	ddm_cmd_if.sink   command,
	ddm_res_if.source result,
	ddm_cfg_if.sink   cfg
);

	// Register file. Writes are to arrive only while the block is idle; the user is bound
	// to this, which the block itself does not enforce. Its ready is tied high.
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_LIN_LIMIT:  cfg_q.lin_limit      <= cfg.data[14:0];
				REG_ANG_LIMIT:  cfg_q.ang_limit      <= cfg.data[14:0];
				REG_TRACK:      cfg_q.track_mm       <= cfg.data[11:0];
				REG_TIMEOUT:    cfg_q.timeout_ticks  <= cfg.data[15:0];
				REG_LEFT_MIN:   cfg_q.left_min_duty  <= cfg.data[6:0];
				REG_RIGHT_MIN:  cfg_q.right_min_duty <= cfg.data[6:0];
				REG_LEFT_COMP:  cfg_q.left_comp      <= comp_t'(cfg.data);
				REG_RIGHT_COMP: cfg_q.right_comp     <= comp_t'(cfg.data);
				default: begin
				end
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	// Output register: a finished item waits here so that the controller can
	// return to idle and accept the next item at once.
	logic       out_valid_q;
	res_t       out_q;
	logic       out_free;
	ctl_cmd_t   ctl;
	dp_status_t dp_status;
	res_t       dp_res;

	assign out_free = !out_valid_q || result.ready;

	ddm_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (command.valid),
		.in_action (command.action),
		.out_free  (out_free),
		.status    (dp_status),
		.cmd       (ctl)
	);

	ddm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.op          (ctl.op),
		.linear_cmd  (command.linear_cmd),
		.angular_cmd (command.angular_cmd),
		.status      (dp_status),
		.res         (dp_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.push) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			out_q <= dp_res;
		end
	end

	assign command.ready       = ctl.in_ready;
	assign result.valid        = out_valid_q;
	assign result.kind         = out_q.kind;
	assign result.left_duty    = out_q.left_duty;
	assign result.left_dir     = out_q.left_dir;
	assign result.right_duty   = out_q.right_duty;
	assign result.right_dir    = out_q.right_dir;
	assign result.body_linear  = out_q.body_linear;
	assign result.body_angular = out_q.body_angular;

	// A result is only pushed into a free output register.
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> out_free)
		else $error("result pushed over an undelivered item");

	// Every accepted item takes the controller out of idle, so ready is low after an acceptance.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		command.valid && command.ready |=> !command.ready)
		else $error("second item accepted while one is in work");

endmodule

[tb/tb_diff_drive_motor_mixer_top.sv]
// Self-checking testbench of the differential-drive motor mixer: directed table, random traffic.
module tb_diff_drive_motor_mixer_top;
	import ddm_pkg::*;

	// Cycles allowed for an item still in flight after the last awaited result.
	localparam int SETTLE_CYCLES   = 40;
	localparam int N_PHASES        = 8;
	localparam int ITEMS_PER_PHASE = 75;
	localparam int AGE_LIMIT       = 65535;
	localparam longint GAIN_ONE    = longint'(1) << GAIN_FRAC;

	// Results that can be read straight off the arithmetic.
	localparam res_t RES_STOP      = '{KIND_STOP, 7'd0, DIR_OFF, 7'd0, DIR_OFF, 16'sd0, 16'sd0};
	localparam res_t RES_IDLE_TICK = '{KIND_TICK, 7'd0, DIR_OFF, 7'd0, DIR_OFF, 16'sd0, 16'sd0};
	localparam res_t RES_FULL_FWD  = '{KIND_TICK, 7'd100, DIR_FWD, 7'd100, DIR_FWD,
		16'sd200, 16'sd0};
	localparam res_t RES_FULL_REV  = '{KIND_TICK, 7'd100, DIR_REV, 7'd100, DIR_REV,
		-16'sd200, 16'sd0};

	// Register settings walked through after the reset defaults: the upper extremes, the
	// lower extremes, a zero linear limit with oversized minimum duties, and a zero
	// angular limit with lopsided gains.
	localparam cfg_t FIXED_SETTINGS [4] = '{
		'{lin_limit: 15'd32767, ang_limit: 15'd32767, track_mm: 12'd4095,
			timeout_ticks: 16'd65535, left_min_duty: 7'd100, right_min_duty: 7'd100,
			left_comp: '{invert: 1'b1, back: 16'hFFFF, fwd: 16'hFFFF},
			right_comp: '{invert: 1'b0, back: 16'hFFFF, fwd: 16'h0000}},
		'{lin_limit: 15'd1, ang_limit: 15'd1, track_mm: 12'd1,
			timeout_ticks: 16'd0, left_min_duty: 7'd0, right_min_duty: 7'd0,
			left_comp: '{invert: 1'b0, back: 16'h0000, fwd: 16'h0000},
			right_comp: '{invert: 1'b1, back: 16'h2000, fwd: 16'h8000}},
		'{lin_limit: 15'd0, ang_limit: 15'd1500, track_mm: 12'd200,
			timeout_ticks: 16'd3, left_min_duty: 7'd127, right_min_duty: 7'd101,
			left_comp: COMP_RESET,
			right_comp: '{invert: 1'b1, back: 16'h4000, fwd: 16'h4000}},
		'{lin_limit: 15'd500, ang_limit: 15'd0, track_mm: 12'd4095,
			timeout_ticks: 16'd1, left_min_duty: 7'd50, right_min_duty: 7'd10,
			left_comp: '{invert: 1'b0, back: 16'h6000, fwd: 16'h3000},
			right_comp: '{invert: 1'b0, back: 16'h4000, fwd: 16'h5555}}
	};

	typedef struct {
		action_t            act;
		logic signed [15:0] lin;
		logic signed [15:0] ang;
		bit                 has_golden;
		res_t               golden;
	} stim_row_t;

	// Directed table, run with the reset defaults. A row with has_golden set carries its
	// result typed in; the other rows are checked against the predictor.
	localparam int N_DIRECTED = 24;
	stim_row_t directed_rows [N_DIRECTED] = '{
		// Tick straight after reset: nothing stored, and the tick ignores its payload.
		'{ACT_TICK, 16'sh7FFF, -16'sh8000, 1'b1, RES_IDLE_TICK},
		'{ACT_CMD, 16'sd0, 16'sd0, 1'b1, RES_STOP},
		// Full forward and full reverse, both clamped to the linear limit.
		'{ACT_CMD, 16'sh7FFF, 16'sd0, 1'b0, RES_IDLE_TICK},
		'{ACT_TICK, 16'sd0, 16'sd0, 1'b1, RES_FULL_FWD},
		'{ACT_CMD, -16'sh8000, 16'sd0, 1'b0, RES_IDLE_TICK},
		'{ACT_TICK, 16'sd0, 16'sd0, 1'b1, RES_FULL_REV},
		// Spinning on the spot, each way, clamped to the angular limit.
		'{ACT_CMD, 16'sd0, 16'sh7FFF, 1'b0, RES_IDLE_TICK},
		'{ACT_TICK, 16'sd0, 16'sd0, 1'b0, RES_IDLE_TICK},
		'{ACT_CMD, 16'sd0, -16'sh8000, 1'b0, RES_IDLE_TICK},
		'{ACT_TICK, -16'sd1, 16'sd1, 1'b0, RES_IDLE_TICK},
		// Both at their limits: one wheel overshoots and both are scaled down together.
		'{ACT_CMD, 16'sh7FFF, 16'sh7FFF, 1'b0, RES_IDLE_TICK},
		'{ACT_TICK, 16'sd0, 16'sd0, 1'b0, RES_IDLE_TICK},
		'{ACT_CMD, -16'sh8000, 16'sh7FFF, 1'b0, RES_IDLE_TICK},
		'{ACT_TICK, 16'sd0, 16'sd0, 1'b0, RES_IDLE_TICK},
		// Just enough to lift the duty to the minimum.
		'{ACT_CMD, 16'sd1, 16'sd0, 1'b0, RES_IDLE_TICK},
		'{ACT_TICK, 16'sd0, 16'sd0, 1'b0, RES_IDLE_TICK},
		// A slight turn gets no duty but shows a direction; slight reverse turning gets the minimum.
		'{ACT_CMD, 16'sd0, 16'sd1, 1'b0, RES_IDLE_TICK},
		'{ACT_TICK, 16'sd0, 16'sd0, 1'b0, RES_IDLE_TICK},
		'{ACT_CMD, -16'sd1, -16'sd1, 1'b0, RES_IDLE_TICK},
		'{ACT_TICK, 16'sd0, 16'sd0, 1'b0, RES_IDLE_TICK},
		// A zero command while moving stops at once and leaves nothing stored.
		'{ACT_CMD, 16'sd0, 16'sd0, 1'b1, RES_STOP},
		'{ACT_TICK, 16'sd0, 16'sd0, 1'b1, RES_IDLE_TICK},
		// Exactly at both limits, so nothing is clamped.
		'{ACT_CMD, 16'sd200, -16'sd2000, 1'b0, RES_IDLE_TICK},
		'{ACT_TICK, 16'sd0, 16'sd0, 1'b0, RES_IDLE_TICK}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ddm_cmd_if cmd_ch();
	ddm_res_if res_ch();
	ddm_cfg_if cfg_ch();

	diff_drive_motor_mixer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.command(cmd_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// The predictor's own copy of the registers and of the stored command.
	cfg_t   model_cfg = CFG_RESET;
	longint held_linear = 0;
	longint held_angular = 0;
	int     ticks_since_cmd = 0;

	res_t awaited_drive_results[$];
	int   mismatch_count = 0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;

	function automatic longint clamp_speed(input longint x, input longint lim);
		return x < -lim ? -lim : (x > lim ? lim : x);
	endfunction

	// Inversion, then the forward or backward gain by the sign, saturated to full scale.
	function automatic longint apply_gain(input longint s, input comp_t c);
		longint g;
		g = s;
		if (c.invert)
			g = -g;
		if (g > 0)
			g = g * longint'(c.fwd) / GAIN_ONE;
		else if (g < 0)
			g = g * longint'(c.back) / GAIN_ONE;
		return g > ONE_Q15 ? ONE_Q15 : (g < -ONE_Q15 ? -ONE_Q15 : g);
	endfunction

	// Bridge direction and duty percent of one wheel. Anything below a thousandth of full
	// scale gets no duty, but the direction still follows the sign.
	function automatic void wheel_drive(input longint s, input logic [6:0] min_duty,
		output logic [6:0] duty, output dir_t dir);
		longint mag;
		longint floor_pct;
		longint pct;
		mag = s < 0 ? -s : s;
		floor_pct = longint'(min_duty);
		pct = 0;
		if (mag * DUTY_ON_SCALE >= ONE_Q15) begin
			pct = (floor_pct * ONE_Q15 + mag * (DUTY_FULL - floor_pct)) / ONE_Q15;
			if (pct > DUTY_FULL)
				pct = DUTY_FULL;
			if (pct < 0)
				pct = 0;
		end
		duty = 7'(pct);
		dir = s > 0 ? DIR_FWD : (s < 0 ? DIR_REV : DIR_OFF);
	endfunction

	// Advances the predictor by one accepted item; returns 1 with the result if it causes one.
	function automatic bit mixer_response(input action_t act, input logic signed [15:0] lin,
		input logic signed [15:0] ang, output res_t r);
		longint full_scale;
		longint wheel_l;
		longint wheel_r;
		longint divisor;
		longint norm_l;
		longint norm_r;
		longint body_lin;
		longint body_ang;
		logic [6:0] duty_l;
		logic [6:0] duty_r;
		dir_t dir_l;
		dir_t dir_r;
		r = RES_IDLE_TICK;
		if (act == ACT_CMD) begin
			held_linear = clamp_speed(longint'(lin), longint'(model_cfg.lin_limit));
			held_angular = clamp_speed(longint'(ang), longint'(model_cfg.ang_limit));
			ticks_since_cmd = 0;
			if (held_linear == 0 && held_angular == 0) begin
				r = RES_STOP;
				return 1'b1;
			end
			return 1'b0;
		end
		if (ticks_since_cmd < AGE_LIMIT)
			ticks_since_cmd++;
		if (ticks_since_cmd > model_cfg.timeout_ticks) begin
			held_linear = 0;
			held_angular = 0;
		end
		// Wheel speeds in units of 1/2000 mm/s, scaled together if either runs past the limit.
		full_scale = SPEED_SCALE * longint'(model_cfg.lin_limit);
		wheel_l = SPEED_SCALE * held_linear - held_angular * longint'(model_cfg.track_mm);
		wheel_r = SPEED_SCALE * held_linear + held_angular * longint'(model_cfg.track_mm);
		divisor = wheel_l < 0 ? -wheel_l : wheel_l;
		if ((wheel_r < 0 ? -wheel_r : wheel_r) > divisor)
			divisor = wheel_r < 0 ? -wheel_r : wheel_r;
		if (divisor < full_scale)
			divisor = full_scale;
		norm_l = 0;
		norm_r = 0;
		body_lin = 0;
		body_ang = 0;
		if (full_scale != 0) begin
			norm_l = wheel_l * ONE_Q15 / divisor;
			norm_r = wheel_r * ONE_Q15 / divisor;
			body_lin = held_linear * full_scale / divisor;
			body_ang = held_angular * full_scale / divisor;
		end
		wheel_drive(apply_gain(norm_l, model_cfg.left_comp), model_cfg.left_min_duty,
			duty_l, dir_l);
		wheel_drive(apply_gain(norm_r, model_cfg.right_comp), model_cfg.right_min_duty,
			duty_r, dir_r);
		r.kind = KIND_TICK;
		r.left_duty = duty_l;
		r.left_dir = dir_l;
		r.right_duty = duty_r;
		r.right_dir = dir_r;
		r.body_linear = 16'(body_lin);
		r.body_angular = 16'(body_ang);
		return 1'b1;
	endfunction

	function automatic logic signed [15:0] speed_within(input logic [14:0] lim);
		int pick;
		pick = int'($urandom_range(0, 2 * lim)) - int'(lim);
		return 16'(pick);
	endfunction

	// Presents one item, holding valid until the block takes it, then books its outcome.
	// Valid is left high on acceptance, so items sent with no idle gap never see it dropped.
	task automatic send_item(input action_t act, input logic signed [15:0] lin,
		input logic signed [15:0] ang, input bit has_golden, input res_t golden);
		res_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.action <= act;
		cmd_ch.linear_cmd <= lin;
		cmd_ch.angular_cmd <= ang;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		if (mixer_response(act, lin, ang, predicted))
			awaited_drive_results.push_back(has_golden ? golden : predicted);
	endtask

	// Holds the sender off until every awaited result has come back. It always waits on the
	// clock before it checks, so valid is never lowered and raised in the same step.
	task automatic drain_results();
		cmd_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (awaited_drive_results.size() != 0);
	endtask

	// Writes all eight registers in index order. The unused upper data bits carry junk,
	// which the block must ignore.
	task automatic apply_settings(input cfg_t s);
		logic [32:0] word;
		for (int i = REG_LIN_LIMIT; i <= REG_RIGHT_COMP; i++) begin
			word = {1'($urandom_range(0, 1)), $urandom()};
			case (cfg_reg_t'(i))
				REG_LIN_LIMIT:  word[14:0] = s.lin_limit;
				REG_ANG_LIMIT:  word[14:0] = s.ang_limit;
				REG_TRACK:      word[11:0] = s.track_mm;
				REG_TIMEOUT:    word[15:0] = s.timeout_ticks;
				REG_LEFT_MIN:   word[6:0] = s.left_min_duty;
				REG_RIGHT_MIN:  word[6:0] = s.right_min_duty;
				REG_LEFT_COMP:  word = s.left_comp;
				REG_RIGHT_COMP: word = s.right_comp;
				default:        word = '0;
			endcase
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= cfg_reg_t'(i);
			cfg_ch.data <= word;
			do
				@(posedge clk);
			while (!cfg_ch.ready);
		end
		cfg_ch.valid <= 1'b0;
		model_cfg = s;
	endtask

	task automatic report_mismatch(input string field, input longint want, input longint seen);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: mismatch in %s: expected %0d, got %0d", $time, field, want, seen);
	endtask

	// Result side: checks every item taken against the oldest awaited result, then decides
	// whether to stall on the next cycle. Values are read as they stood at the edge.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (awaited_drive_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: result item arrived with none awaited", $time);
			end else begin
				want = awaited_drive_results.pop_front();
				if (res_ch.kind !== want.kind)
					report_mismatch("kind", want.kind, res_ch.kind);
				if (res_ch.left_duty !== want.left_duty)
					report_mismatch("left_duty", want.left_duty, res_ch.left_duty);
				if (res_ch.left_dir !== want.left_dir)
					report_mismatch("left_dir", want.left_dir, res_ch.left_dir);
				if (res_ch.right_duty !== want.right_duty)
					report_mismatch("right_duty", want.right_duty, res_ch.right_duty);
				if (res_ch.right_dir !== want.right_dir)
					report_mismatch("right_dir", want.right_dir, res_ch.right_dir);
				if (res_ch.body_linear !== want.body_linear)
					report_mismatch("body_linear", want.body_linear, res_ch.body_linear);
				if (res_ch.body_angular !== want.body_angular)
					report_mismatch("body_angular", want.body_angular, res_ch.body_angular);
			end
		end
		res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Stimulus: reset, the directed table, then eight phases of random traffic, each after
	// the first opened with a fresh register setting once the block has gone quiet.
	initial begin
		cfg_t settings;
		int burst;
		int phase_items;
		logic signed [15:0] lin;
		logic signed [15:0] ang;
		cmd_ch.valid <= 1'b0;
		cmd_ch.action <= ACT_CMD;
		cmd_ch.linear_cmd <= '0;
		cmd_ch.angular_cmd <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_LIN_LIMIT;
		cfg_ch.data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 26;
		recv_idle_pct = 75;
		foreach (directed_rows[i])
			send_item(directed_rows[i].act, directed_rows[i].lin, directed_rows[i].ang,
				directed_rows[i].has_golden, directed_rows[i].golden);

		for (int phase = 0; phase < N_PHASES; phase++) begin
			// The sender idles little at first while the receiver stalls more, then the
			// roles swap, and the last phases run with no gaps on either side.
			if (phase < 3) begin
				send_idle_pct = 26;
				recv_idle_pct = 75;
			end else if (phase < 6) begin
				send_idle_pct = 75;
				recv_idle_pct = 26;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			if (phase > 0) begin
				// A command that causes no result may still be in the block, so wait a
				// little beyond the last result before touching the registers.
				drain_results();
				repeat (SETTLE_CYCLES) @(posedge clk);
				if (phase <= 4) begin
					settings = FIXED_SETTINGS[phase - 1];
				end else begin
					settings.lin_limit = 15'($urandom_range(1, 4000));
					settings.ang_limit = 15'($urandom_range(1, 6000));
					settings.track_mm = 12'($urandom_range(1, 4095));
					settings.timeout_ticks = 16'($urandom_range(0, 10));
					settings.left_min_duty = 7'($urandom_range(0, 127));
					settings.right_min_duty = 7'($urandom_range(0, 127));
					settings.left_comp.invert = 1'($urandom_range(0, 1));
					settings.left_comp.back = 16'($urandom_range(0, 65535));
					settings.left_comp.fwd = 16'($urandom_range(0, 65535));
					settings.right_comp.invert = 1'($urandom_range(0, 1));
					settings.right_comp.back = 16'($urandom_range(0, 65535));
					settings.right_comp.fwd = 16'($urandom_range(0, 65535));
				end
				apply_settings(settings);
			end

			phase_items = 0;
			while (phase_items < ITEMS_PER_PHASE) begin
				// Now and then the sender waits until every awaited result has come back.
				if ($urandom_range(0, 29) == 0)
					drain_results();

				// Mostly a command followed by a run of ticks; sometimes the command is
				// left out, so ticks keep ageing whatever was stored before.
				if ($urandom_range(0, 9) != 0) begin
					case ($urandom_range(0, 9))
						0: begin
							lin = '0;
							ang = '0;
						end
						1: begin
							lin = '0;
							ang = speed_within(model_cfg.ang_limit);
						end
						2: begin
							lin = speed_within(model_cfg.lin_limit);
							ang = '0;
						end
						3, 4, 5, 6: begin
							lin = speed_within(model_cfg.lin_limit);
							ang = speed_within(model_cfg.ang_limit);
						end
						default: begin
							// Anything at all, mostly beyond the limits.
							lin = 16'($urandom());
							ang = 16'($urandom());
						end
					endcase
					send_item(ACT_CMD, lin, ang, 1'b0, RES_IDLE_TICK);
					phase_items++;
				end

				// Occasionally the run of ticks outlasts a short timeout.
				if ($urandom_range(0, 7) == 0 && model_cfg.timeout_ticks < 40)
					burst = int'(model_cfg.timeout_ticks) + $urandom_range(1, 3);
				else
					burst = $urandom_range(0, 4);
				repeat (burst) begin
					send_item(ACT_TICK, 16'($urandom()), 16'($urandom()), 1'b0,
						RES_IDLE_TICK);
					phase_items++;
				end
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && awaited_drive_results.size() == 0)
			$display("tb_diff_drive_motor_mixer_top: done, clean");
		else
			$display("tb_diff_drive_motor_mixer_top: done, errors");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run, even with every stall at its worst.
	initial begin
		#2000000;
		$display("tb_diff_drive_motor_mixer_top: done, errors");
		$finish;
	end

endmodule
